// ===== rtl/core/gbs_pkg.sv =====
// Shared types, widths and codes for the grid bilinear sampler.
`default_nettype none

package gbs_pkg;

  localparam int unsigned COL_BITS       = 8;
  localparam int unsigned ROW_BITS       = 8;
  localparam int unsigned MAX_COLS       = 1 << COL_BITS;
  localparam int unsigned MAX_ROWS       = 1 << ROW_BITS;
  localparam int unsigned HEIGHT_BITS    = 16;
  localparam int unsigned WRITE_BITS     = 16;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned COORD_BITS     = FRAC_BITS + 1;
  localparam int unsigned WEIGHT_BITS    = FRAC_BITS + 1;
  localparam int unsigned SX_BITS        = FRAC_BITS + COL_BITS;
  localparam int unsigned SY_BITS        = FRAC_BITS + ROW_BITS;
  localparam int unsigned PROD_BITS      = HEIGHT_BITS + WEIGHT_BITS + 1;
  localparam int unsigned ROW_BLEND_BITS = HEIGHT_BITS + FRAC_BITS;
  localparam int unsigned ACC_BITS       = ROW_BLEND_BITS + WEIGHT_BITS;

  localparam int unsigned NUM_BANKS      = 4;
  localparam int unsigned BANK_ADDR_BITS = (COL_BITS - 1) + (ROW_BITS - 1);
  localparam int unsigned BANK_DEPTH     = 1 << BANK_ADDR_BITS;

  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = COL_BITS + 1;

  localparam logic [COORD_BITS-1:0] ONE_Q16 = COORD_BITS'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef logic [NUM_BANKS-1:0][HEIGHT_BITS-1:0] bank_data_t;

  typedef struct packed {
    logic                 vld;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic                 x0_odd;
    logic                 x1_odd;
    logic                 y0_odd;
    logic                 y1_odd;
  } blend_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/gbs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module gbs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrBits = $clog2(Depth)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbs_blend.sv =====
// Interpolation pipeline: neighbour selection, x blend, y blend and truncation.
`default_nettype none

module gbs_blend import gbs_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire blend_ctl_t                    ctl_i,
  input  wire bank_data_t                    bank_data_i,
  output logic                               done_o,
  output logic signed [HEIGHT_BITS-1:0]      height_o
);

  logic signed [HEIGHT_BITS-1:0] h00, h10, h01, h11;
  logic signed [WEIGHT_BITS:0]   wx0, wx1;
  logic signed [PROD_BITS-1:0]   p00_d, p10_d, p01_d, p11_d;
  logic signed [PROD_BITS-1:0]   p00_q, p10_q, p01_q, p11_q;
  logic [FRAC_BITS-1:0]          fy_a_q, fy_b_q;
  logic                          vld_a_q, vld_b_q, vld_c_q;
  logic signed [ROW_BLEND_BITS-1:0] a_d, b_d, a_q, b_q;
  logic signed [WEIGHT_BITS:0]   wy0, wy1;
  logic signed [ACC_BITS-1:0]    ma_d, mb_d, ma_q, mb_q;
  logic signed [ACC_BITS-1:0]    acc;
  logic                          round_up;
  logic signed [HEIGHT_BITS-1:0] height_d, height_q;
  logic                          done_q;

  always_comb begin
    h00 = bank_data_i[{ctl_i.y0_odd, ctl_i.x0_odd}];
    h10 = bank_data_i[{ctl_i.y0_odd, ctl_i.x1_odd}];
    h01 = bank_data_i[{ctl_i.y1_odd, ctl_i.x0_odd}];
    h11 = bank_data_i[{ctl_i.y1_odd, ctl_i.x1_odd}];
    wx1 = $signed({2'b00, ctl_i.fx});
    wx0 = $signed({1'b0, ONE_Q16 - {1'b0, ctl_i.fx}});
    p00_d = PROD_BITS'(h00 * wx0);
    p10_d = PROD_BITS'(h10 * wx1);
    p01_d = PROD_BITS'(h01 * wx0);
    p11_d = PROD_BITS'(h11 * wx1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      vld_a_q <= ctl_i.vld;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      done_q  <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p00_q  <= p00_d;
    p10_q  <= p10_d;
    p01_q  <= p01_d;
    p11_q  <= p11_d;
    fy_a_q <= ctl_i.fy;
  end

  // The row blends are convex combinations, so they fit the narrower width.
  always_comb begin
    a_d = ROW_BLEND_BITS'(p00_q + p10_q);
    b_d = ROW_BLEND_BITS'(p01_q + p11_q);
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    fy_b_q <= fy_a_q;
  end

  always_comb begin
    wy1  = $signed({2'b00, fy_b_q});
    wy0  = $signed({1'b0, ONE_Q16 - {1'b0, fy_b_q}});
    ma_d = ACC_BITS'(a_q * wy0);
    mb_d = ACC_BITS'(b_q * wy1);
  end

  always_ff @(posedge clk_i) begin
    ma_q <= ma_d;
    mb_q <= mb_d;
  end

  // Truncation toward zero: a negative sum with a nonzero fraction moves up by one.
  always_comb begin
    acc      = ma_q + mb_q;
    round_up = acc[ACC_BITS-1] && (acc[2*FRAC_BITS-1:0] != '0);
    height_d = acc[2*FRAC_BITS +: HEIGHT_BITS] + HEIGHT_BITS'(round_up);
  end

  always_ff @(posedge clk_i) begin
    height_q <= height_d;
  end

  assign done_o   = done_q;
  assign height_o = height_q;

endmodule

`default_nettype wire

// ===== rtl/core/grid_bilinear_sampler.sv =====
// Top level of the grid bilinear sampler: command decode, banked height store, blend pipeline.
//
// Usage: a command beat is taken on every rising edge with start_i high; busy_o is
// always low, so one beat per cycle is sustained. cmd_i selects a height write
// (write_col_i, write_row_i, write_value_i) or a sample (sample_u_i, sample_v_i in
// Q1.16). A write gives no result. A sample gives one result beat: done_o rises once the
// sample has passed the command register, the bank read and the blend pipeline, and holds
// sampled_height_o for exactly one cycle, in which the receiver takes the beat.
// The heights sit in four banks split by column and row parity, each with one write
// port and one registered read port, so the four neighbours of a sample are read in
// the same cycle and a write takes one bank access; reads and writes stay in command order
// and need no interlock.
// The result channel has no back pressure; the receiver must take every beat.
// Configuration (grid_width, grid_height) is written through cfg_we_i, cfg_idx_i
// and cfg_wdata_i while no sample is in flight. Reset clears the pipeline and sets
// both sizes to 256; the height store keeps no reset value and must be written
// before it is sampled.
`default_nettype none

module grid_bilinear_sampler import gbs_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_wdata_i,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          cmd_i,
  input  wire logic [COL_BITS-1:0]           write_col_i,
  input  wire logic [ROW_BITS-1:0]           write_row_i,
  input  wire logic signed [WRITE_BITS-1:0]  write_value_i,
  input  wire logic [COORD_BITS-1:0]         sample_u_i,
  input  wire logic [COORD_BITS-1:0]         sample_v_i,
  output logic                               done_o,
  output logic signed [HEIGHT_BITS-1:0]      sampled_height_o
);

  logic                      accept;
  logic [COL_BITS-1:0]       wm1_d, wm1_q;
  logic [ROW_BITS-1:0]       hm1_d, hm1_q;
  logic [COORD_BITS-1:0]     u_sat, v_sat;
  logic [SX_BITS-1:0]        sx_d, s1_sx_q;
  logic [SY_BITS-1:0]        sy_d, s1_sy_q;
  logic                      s1_vld_q;
  logic                      s1_cmd_q;
  logic [COL_BITS-1:0]       s1_col_q;
  logic [ROW_BITS-1:0]       s1_row_q;
  logic [HEIGHT_BITS-1:0]    s1_val_q;
  logic [COL_BITS-1:0]       x0, x1;
  logic [ROW_BITS-1:0]       y0, y1;
  logic                      s1_write, s1_sample;
  logic [COL_BITS-1:0]       col_sel [NUM_BANKS];
  logic [ROW_BITS-1:0]       row_sel [NUM_BANKS];
  logic [NUM_BANKS-1:0]      bank_we;
  logic [BANK_ADDR_BITS-1:0] bank_waddr;
  bank_data_t                bank_rdata;
  blend_ctl_t                ctl_d, ctl_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    wm1_d = wm1_q;
    hm1_d = hm1_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH: begin
          if (cfg_wdata_i == '0) begin
            wm1_d = '0;
          end else if (cfg_wdata_i > CFG_DATA_BITS'(MAX_COLS)) begin
            wm1_d = COL_BITS'(MAX_COLS - 1);
          end else begin
            wm1_d = COL_BITS'(cfg_wdata_i - CFG_DATA_BITS'(1));
          end
        end
        REG_GRID_HEIGHT: begin
          if (cfg_wdata_i == '0) begin
            hm1_d = '0;
          end else if (cfg_wdata_i > CFG_DATA_BITS'(MAX_ROWS)) begin
            hm1_d = ROW_BITS'(MAX_ROWS - 1);
          end else begin
            hm1_d = ROW_BITS'(cfg_wdata_i - CFG_DATA_BITS'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q    <= COL_BITS'(MAX_COLS - 1);
      hm1_q    <= ROW_BITS'(MAX_ROWS - 1);
      s1_vld_q <= 1'b0;
    end else begin
      wm1_q    <= wm1_d;
      hm1_q    <= hm1_d;
      s1_vld_q <= accept;
    end
  end

  always_comb begin
    u_sat = (sample_u_i > ONE_Q16) ? ONE_Q16 : sample_u_i;
    v_sat = (sample_v_i > ONE_Q16) ? ONE_Q16 : sample_v_i;
    sx_d  = SX_BITS'(u_sat) * SX_BITS'(wm1_q);
    sy_d  = SY_BITS'(v_sat) * SY_BITS'(hm1_q);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= cmd_i;
      s1_col_q <= write_col_i;
      s1_row_q <= write_row_i;
      s1_val_q <= HEIGHT_BITS'(write_value_i);
      s1_sx_q  <= sx_d;
      s1_sy_q  <= sy_d;
    end
  end

  always_comb begin
    x0 = s1_sx_q[FRAC_BITS +: COL_BITS];
    y0 = s1_sy_q[FRAC_BITS +: ROW_BITS];
    x1 = (x0 < wm1_q) ? x0 + COL_BITS'(1) : wm1_q;
    y1 = (y0 < hm1_q) ? y0 + ROW_BITS'(1) : hm1_q;
    s1_write   = s1_vld_q && (s1_cmd_q == CMD_WRITE);
    s1_sample  = s1_vld_q && (s1_cmd_q == CMD_SAMPLE);
    bank_waddr = {s1_row_q[ROW_BITS-1:1], s1_col_q[COL_BITS-1:1]};
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic [1:0] BSEL = 2'(b);

    assign col_sel[b]  = (x0[0] == BSEL[0]) ? x0 : x1;
    assign row_sel[b]  = (y0[0] == BSEL[1]) ? y0 : y1;
    assign bank_we[b]  = s1_write && ({s1_row_q[0], s1_col_q[0]} == BSEL);

    gbs_ram #(
      .Width (HEIGHT_BITS),
      .Depth (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (bank_waddr),
      .wdata_i (s1_val_q),
      .raddr_i ({row_sel[b][ROW_BITS-1:1], col_sel[b][COL_BITS-1:1]}),
      .rdata_o (bank_rdata[b])
    );
  end

  always_comb begin
    ctl_d.vld    = s1_sample;
    ctl_d.fx     = s1_sx_q[FRAC_BITS-1:0];
    ctl_d.fy     = s1_sy_q[FRAC_BITS-1:0];
    ctl_d.x0_odd = x0[0];
    ctl_d.x1_odd = x1[0];
    ctl_d.y0_odd = y0[0];
    ctl_d.y1_odd = y1[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  gbs_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_q),
    .bank_data_i (bank_rdata),
    .done_o      (done_o),
    .height_o    (sampled_height_o)
  );

  a_done_follows_sample: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept && (cmd_i == CMD_SAMPLE), 6)
  ) else $error("result beat without a matching sample command");

  a_sample_gives_done: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == CMD_SAMPLE)) |-> ##6 done_o
  ) else $error("sample command lost in the pipeline");

  a_neighbours_in_grid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_sample |-> (x0 <= wm1_q) && (x1 <= wm1_q) && (y0 <= hm1_q) && (y1 <= hm1_q)
  ) else $error("neighbour outside the grid in use");

  a_one_bank_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bank_we) && !(s1_sample && (bank_we != '0))
  ) else $error("bank write collides with a sample read");

endmodule

`default_nettype wire

// ===== tb/grid_bilinear_sampler_test.sv =====
// Self-checking testbench for the grid bilinear sampler: directed table, then random phases.
`timescale 1ns / 1ps

module grid_bilinear_sampler_test import gbs_pkg::*; ();

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = CFG_IDX_BITS'(3);
  localparam logic [COORD_BITS-1:0]   COORD_MAX   = '1;
  localparam int SETTLE_CYCLES  = 8;
  localparam int NUM_PHASES     = 10;
  localparam int BEATS_PER_PHASE = 165;

  typedef struct {
    logic                          cmd;
    logic [COL_BITS-1:0]           col;
    logic [ROW_BITS-1:0]           row;
    logic signed [WRITE_BITS-1:0]  value;
    logic [COORD_BITS-1:0]         u;
    logic [COORD_BITS-1:0]         v;
  } grid_beat_t;

  typedef struct {
    bit                            is_cfg;
    logic [CFG_IDX_BITS-1:0]       idx;
    logic [CFG_DATA_BITS-1:0]      data;
    grid_beat_t                    beat;
    bit                            known;
    logic signed [HEIGHT_BITS-1:0] height;
  } script_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_wdata_i = '0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic                          cmd_i = CMD_WRITE;
  logic [COL_BITS-1:0]           write_col_i = '0;
  logic [ROW_BITS-1:0]           write_row_i = '0;
  logic signed [WRITE_BITS-1:0]  write_value_i = '0;
  logic [COORD_BITS-1:0]         sample_u_i = '0;
  logic [COORD_BITS-1:0]         sample_v_i = '0;
  logic                          done_o;
  logic signed [HEIGHT_BITS-1:0] sampled_height_o;

  logic signed [HEIGHT_BITS-1:0] heights [MAX_COLS*MAX_ROWS];
  bit                            height_written [MAX_COLS*MAX_ROWS];
  logic [CFG_DATA_BITS-1:0]      grid_cols_raw = CFG_DATA_BITS'(MAX_COLS);
  logic [CFG_DATA_BITS-1:0]      grid_rows_raw = CFG_DATA_BITS'(MAX_ROWS);
  logic signed [HEIGHT_BITS-1:0] pending_heights [$];

  int n_errors = 0;
  int n_beats = 0;
  int n_samples = 0;
  int n_writes = 0;
  int n_cfg_writes = 0;
  int burst_left = 0;

  grid_bilinear_sampler DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .write_col_i      (write_col_i),
    .write_row_i      (write_row_i),
    .write_value_i    (write_value_i),
    .sample_u_i       (sample_u_i),
    .sample_v_i       (sample_v_i),
    .done_o           (done_o),
    .sampled_height_o (sampled_height_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int eff_size(input logic [CFG_DATA_BITS-1:0] raw, input int limit);
    if (raw == 0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  function automatic void cell_of(input logic [COORD_BITS-1:0] coord, input int size,
                                  output int c0, output int c1, output longint frac);
    longint q;
    longint s;
    q = (coord > ONE_Q16) ? longint'(ONE_Q16) : longint'(coord);
    s = q * longint'(size - 1);
    c0 = int'(s >> FRAC_BITS);
    frac = s & ((longint'(1) << FRAC_BITS) - 1);
    c1 = (c0 + 1 < size) ? c0 + 1 : size - 1;
  endfunction

  function automatic longint height_at(input int col, input int row);
    return longint'(heights[row * MAX_COLS + col]);
  endfunction

  function automatic logic signed [HEIGHT_BITS-1:0] blended_height(
      input logic [COORD_BITS-1:0] u, input logic [COORD_BITS-1:0] v);
    int x0, x1, y0, y1;
    longint fx, fy, a, b, acc, unity;
    unity = longint'(ONE_Q16);
    cell_of(u, eff_size(grid_cols_raw, MAX_COLS), x0, x1, fx);
    cell_of(v, eff_size(grid_rows_raw, MAX_ROWS), y0, y1, fy);
    a = height_at(x0, y0) * (unity - fx) + height_at(x1, y0) * fx;
    b = height_at(x0, y1) * (unity - fx) + height_at(x1, y1) * fx;
    acc = a * (unity - fy) + b * fy;
    return HEIGHT_BITS'(acc / (longint'(1) <<< (2 * FRAC_BITS)));
  endfunction

  function automatic logic signed [WRITE_BITS-1:0] rand_height();
    case ($urandom_range(0, 15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return '1;
      default: return WRITE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return ONE_Q16;
      2: return COORD_BITS'($urandom_range(65537, 131071));
      default: return COORD_BITS'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_BITS'($urandom_range(257, 511));
      2: return CFG_DATA_BITS'(MAX_COLS);
      3: return CFG_DATA_BITS'($urandom_range(9, 64));
      default: return CFG_DATA_BITS'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic grid_beat_t rand_beat(input logic cmd);
    grid_beat_t b;
    b.cmd = cmd;
    b.col = COL_BITS'($urandom_range(0, MAX_COLS - 1));
    b.row = ROW_BITS'($urandom_range(0, MAX_ROWS - 1));
    b.value = rand_height();
    b.u = COORD_BITS'($urandom_range(0, 131071));
    b.v = COORD_BITS'($urandom_range(0, 131071));
    return b;
  endfunction

  function automatic int unsigned next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 60);
    return $urandom_range(0, 6);
  endfunction

  function automatic script_row_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
    script_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic script_row_t write_row(input int col, input int row,
                                            input logic signed [WRITE_BITS-1:0] value);
    script_row_t r;
    r = '{default: '0};
    r.beat.cmd = CMD_WRITE;
    r.beat.col = COL_BITS'(col);
    r.beat.row = ROW_BITS'(row);
    r.beat.value = value;
    return r;
  endfunction

  function automatic script_row_t sample_row(input logic [COORD_BITS-1:0] u,
                                             input logic [COORD_BITS-1:0] v, input bit known,
                                             input logic signed [HEIGHT_BITS-1:0] height);
    script_row_t r;
    r = '{default: '0};
    r.beat.cmd = CMD_SAMPLE;
    r.beat.u = u;
    r.beat.v = v;
    r.known = known;
    r.height = height;
    return r;
  endfunction

  // Called just after a rising edge; returns just after the edge that accepted the beat.
  task automatic send_beat(input grid_beat_t b, input bit known,
                           input logic signed [HEIGHT_BITS-1:0] height);
    int unsigned gap;
    int idx;
    gap = next_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= b.cmd;
    write_col_i <= b.col;
    write_row_i <= b.row;
    write_value_i <= b.value;
    sample_u_i <= b.u;
    sample_v_i <= b.v;
    do @(posedge clk_i); while (busy_o);
    n_beats++;
    if (b.cmd == CMD_WRITE) begin
      idx = int'(b.row) * MAX_COLS + int'(b.col);
      heights[idx] = b.value;
      height_written[idx] = 1'b1;
      n_writes++;
    end else begin
      pending_heights.push_back(known ? height : blended_height(b.u, b.v));
      n_samples++;
    end
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_heights.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_GRID_WIDTH) grid_cols_raw = data;
    else if (idx == REG_GRID_HEIGHT) grid_rows_raw = data;
    n_cfg_writes++;
  endtask

  // Every neighbour a sample reads must hold a written height first.
  task automatic fill_neighbours(input logic [COORD_BITS-1:0] u, input logic [COORD_BITS-1:0] v);
    int cx[2];
    int ry[2];
    longint frac;
    grid_beat_t b;
    cell_of(u, eff_size(grid_cols_raw, MAX_COLS), cx[0], cx[1], frac);
    cell_of(v, eff_size(grid_rows_raw, MAX_ROWS), ry[0], ry[1], frac);
    foreach (cx[i]) begin
      foreach (ry[j]) begin
        if (!height_written[ry[j] * MAX_COLS + cx[i]]) begin
          b = rand_beat(CMD_WRITE);
          b.col = COL_BITS'(cx[i]);
          b.row = ROW_BITS'(ry[j]);
          send_beat(b, 1'b0, '0);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_heights.size() == 0) begin
        $error("sampled_height: no sample outstanding, got %0d", sampled_height_o);
        n_errors++;
      end else begin
        logic signed [HEIGHT_BITS-1:0] expected_height;
        expected_height = pending_heights.pop_front();
        if (sampled_height_o !== expected_height) begin
          $error("sampled_height: expected %0d, got %0d", expected_height, sampled_height_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    script_row_t script [$];
    grid_beat_t b;
    int phase_end;
    int pick;
    int waited;
    logic [COORD_BITS-1:0] u;
    logic [COORD_BITS-1:0] v;

    script.push_back(cfg_row(REG_GRID_WIDTH, 2));
    script.push_back(cfg_row(REG_GRID_HEIGHT, 2));
    script.push_back(cfg_row(REG_SPARE_A, 5));
    script.push_back(cfg_row(REG_SPARE_B, 511));
    script.push_back(write_row(0, 0, 100));
    script.push_back(write_row(1, 0, -32768));
    script.push_back(write_row(0, 1, 32767));
    script.push_back(write_row(1, 1, -1));
    script.push_back(sample_row(0, 0, 1'b1, 100));
    script.push_back(sample_row(ONE_Q16, 0, 1'b1, -32768));
    script.push_back(sample_row(0, ONE_Q16, 1'b1, 32767));
    script.push_back(sample_row(ONE_Q16, ONE_Q16, 1'b1, -1));
    script.push_back(sample_row(COORD_MAX, COORD_MAX, 1'b1, -1));
    script.push_back(sample_row(32768, 32768, 1'b0, '0));
    script.push_back(sample_row(1, 65535, 1'b0, '0));
    script.push_back(write_row(255, 255, -32768));
    script.push_back(write_row(0, 255, 32767));
    script.push_back(cfg_row(REG_GRID_WIDTH, 0));
    script.push_back(cfg_row(REG_GRID_HEIGHT, 511));
    script.push_back(sample_row(COORD_MAX, COORD_MAX, 1'b1, 32767));
    script.push_back(sample_row(0, 0, 1'b1, 100));
    script.push_back(sample_row(12345, 0, 1'b0, '0));
    script.push_back(cfg_row(REG_GRID_WIDTH, 256));
    script.push_back(cfg_row(REG_GRID_HEIGHT, 256));
    script.push_back(sample_row(ONE_Q16, ONE_Q16, 1'b1, -32768));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) write_register(script[i].idx, script[i].data);
      else send_beat(script[i].beat, script[i].known, script[i].height);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(REG_GRID_WIDTH, (p == 0) ? CFG_DATA_BITS'(1) :
                     (p == 1) ? CFG_DATA_BITS'(MAX_COLS) : rand_size());
      write_register(REG_GRID_HEIGHT, (p == 0) ? CFG_DATA_BITS'(MAX_ROWS) :
                     (p == 1) ? CFG_DATA_BITS'(1) : rand_size());
      phase_end = n_beats + BEATS_PER_PHASE;
      while (n_beats < phase_end) begin
        if ($urandom_range(0, 49) == 0) wait_for_results();
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          u = rand_coord();
          v = rand_coord();
          fill_neighbours(u, v);
          b = rand_beat(CMD_SAMPLE);
          b.u = u;
          b.v = v;
        end else if (pick < 90) begin
          b = rand_beat(CMD_WRITE);
          b.col = COL_BITS'($urandom_range(0, eff_size(grid_cols_raw, MAX_COLS) - 1));
          b.row = ROW_BITS'($urandom_range(0, eff_size(grid_rows_raw, MAX_ROWS) - 1));
        end else begin
          b = rand_beat(CMD_WRITE);
        end
        send_beat(b, 1'b0, '0);
      end
    end

    start_i <= 1'b0;
    waited = 0;
    while (pending_heights.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_heights.size() != 0) begin
      $error("sampled_height: %0d expected results never arrived", pending_heights.size());
      n_errors++;
    end

    $display("Sent %0d command beats: %0d samples checked and %0d height writes.",
             n_beats, n_samples, n_writes);
    $display("Size registers written %0d times, over %0d random grid settings and the edges.",
             n_cfg_writes, NUM_PHASES);
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
